/* rtl/disc_cell_coverage_macros.svh */
// Assertion macros used by the disc cell coverage checker.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef DISC_CELL_COVERAGE_MACROS_SVH
`define DISC_CELL_COVERAGE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dcc_pkg.sv */
// Shared types and constants for the disc cell coverage block.
// No dependencies; imported by every module of the block.
package dcc_pkg;

    localparam int CW   = 46;   // signed cell-unit coordinates, Q.16
    localparam int MW   = 44;   // magnitudes of those coordinates
    localparam int SQW  = 2 * MW;
    localparam int RW   = 42;   // scaled radius and half chord
    localparam int R2W  = 2 * RW;
    localparam int LENW = 17;
    localparam int ACCW = 32;
    localparam int COVW = 17;
    localparam int NW   = 11;

    localparam logic signed [CW-1:0] CELL_ONE  = 46'sd65536;
    localparam logic signed [CW-1:0] HALF_CELL = 46'sd32768;
    localparam logic [COVW-1:0]      FULL_COVER = 17'd65536;

    localparam logic [1:0] KIND_OUTSIDE = 2'd0;
    localparam logic [1:0] KIND_INSIDE  = 2'd1;
    localparam logic [1:0] KIND_PARTIAL = 2'd2;

    // One classified request passed from the front to the back.
    typedef struct packed {
        logic [1:0]     kind;
        logic [CW-1:0]  ax;     // left edge minus centre x
        logic [CW-1:0]  ay;     // bottom edge minus centre y
        logic [R2W-1:0] r2;
        logic [SQW-1:0] ax2;    // ax squared, seeds the column walk
    } job_t;

endpackage

/* rtl/dcc_front.sv */
// Front end: takes a request, scales it to cell units and classifies it.
// Uses dcc_pkg; squares are formed by one shift-add unit, one bit a cycle.
module dcc_front
    import dcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [NW-1:0]       n_cfg,
    input  logic                push,
    output logic                full,
    input  logic signed [15:0]  cell_x,
    input  logic signed [15:0]  cell_y,
    input  logic signed [31:0]  centre_x,
    input  logic signed [31:0]  centre_y,
    input  logic [30:0]         radius,
    output job_t                job,
    output logic                job_push,
    input  logic                job_full
);

    typedef enum logic [2:0] {F_IDLE, F_MUL, F_GEO, F_LOAD, F_SQ, F_PUSH} fstate_t;

    fstate_t                state_reg;
    logic [5:0]             cnt_reg;
    logic [2:0]             idx_reg;

    logic signed [15:0]     cell_x_reg, cell_y_reg;
    logic signed [31:0]     centre_x_reg, centre_y_reg;
    logic [30:0]            radius_reg;
    logic signed [43:0]     cxp_reg, cyp_reg;
    logic [RW-1:0]          r_reg;
    logic signed [CW-1:0]   ax_reg, ay_reg;
    logic [5:0][MW-1:0]     op_reg;
    logic [5:0][SQW-1:0]    sq_reg;
    logic [SQW-1:0]         mcand_reg, acc_reg;
    logic [MW-1:0]          mul_reg;

    logic [NW-1:0]          n_eff;
    logic signed [CW-1:0]   ax, ay;
    logic [2*MW-1:0]        rng_x, rng_y;
    logic [SQW-1:0]         acc_add;
    logic [SQW:0]           near2, far2, r2_ext;
    logic [1:0]             kind;

    function automatic logic [MW-1:0] mag(input logic signed [CW-1:0] v);
        logic [CW-1:0] m;
        m = v[CW-1] ? CW'(-v) : CW'(v);
        return m[MW-1:0];
    endfunction

    // Returns {nearest, farthest} distance of the cell span [lo, lo+1).
    function automatic logic [2*MW-1:0] axis_range(input logic signed [CW-1:0] lo);
        logic signed [CW-1:0] hi;
        logic [MW-1:0]        ml, mh, nr, fr;
        hi = lo + CELL_ONE;
        ml = mag(lo);
        mh = mag(hi);
        fr = (ml > mh) ? ml : mh;
        nr = (lo < 0 && hi > 0) ? '0 : ((ml < mh) ? ml : mh);
        return {nr, fr};
    endfunction

    assign n_eff = (n_cfg == '0) ? NW'(1) : n_cfg;
    assign full  = (state_reg != F_IDLE);

    assign ax = {{14{cell_x_reg[15]}}, cell_x_reg, 16'h0} - HALF_CELL
                - {{(CW-44){cxp_reg[43]}}, cxp_reg};
    assign ay = {{14{cell_y_reg[15]}}, cell_y_reg, 16'h0} - HALF_CELL
                - {{(CW-44){cyp_reg[43]}}, cyp_reg};
    assign rng_x = axis_range(ax);
    assign rng_y = axis_range(ay);

    assign acc_add = mul_reg[0] ? acc_reg + mcand_reg : acc_reg;

    // Operand order: 0 radius, 1 near x, 2 far x, 3 near y, 4 far y, 5 |ax|.
    assign near2  = {1'b0, sq_reg[1]} + {1'b0, sq_reg[3]};
    assign far2   = {1'b0, sq_reg[2]} + {1'b0, sq_reg[4]};
    assign r2_ext = {{(SQW+1-R2W){1'b0}}, sq_reg[0][R2W-1:0]};

    always_comb
    begin
        if (near2 > r2_ext)
        begin
            kind = KIND_OUTSIDE;
        end
        else if (far2 < r2_ext)
        begin
            kind = KIND_INSIDE;
        end
        else
        begin
            kind = KIND_PARTIAL;
        end
    end

    assign job.kind = kind;
    assign job.ax   = ax_reg;
    assign job.ay   = ay_reg;
    assign job.r2   = sq_reg[0][R2W-1:0];
    assign job.ax2  = sq_reg[5];
    assign job_push = (state_reg == F_PUSH) && !job_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    state_reg <= F_GEO;
                end
                F_GEO:
                begin
                    idx_reg   <= '0;
                    state_reg <= F_LOAD;
                end
                F_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= F_SQ;
                end
                F_SQ:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(MW - 1))
                    begin
                        if (idx_reg == 3'd5)
                        begin
                            state_reg <= F_PUSH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= F_LOAD;
                        end
                    end
                end
                F_PUSH:
                begin
                    if (!job_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            cell_x_reg   <= cell_x;
            cell_y_reg   <= cell_y;
            centre_x_reg <= centre_x;
            centre_y_reg <= centre_y;
            radius_reg   <= radius;
        end
        if (state_reg == F_MUL)
        begin
            cxp_reg <= centre_x_reg * $signed({1'b0, n_eff});
            cyp_reg <= centre_y_reg * $signed({1'b0, n_eff});
            r_reg   <= radius_reg * n_eff;
        end
        if (state_reg == F_GEO)
        begin
            ax_reg    <= ax;
            ay_reg    <= ay;
            op_reg[0] <= {{(MW-RW){1'b0}}, r_reg};
            op_reg[1] <= rng_x[2*MW-1:MW];
            op_reg[2] <= rng_x[MW-1:0];
            op_reg[3] <= rng_y[2*MW-1:MW];
            op_reg[4] <= rng_y[MW-1:0];
            op_reg[5] <= mag(ax);
        end
        if (state_reg == F_LOAD)
        begin
            mcand_reg <= {{MW{1'b0}}, op_reg[idx_reg]};
            mul_reg   <= op_reg[idx_reg];
            acc_reg   <= '0;
        end
        if (state_reg == F_SQ)
        begin
            acc_reg   <= acc_add;
            mcand_reg <= {mcand_reg[SQW-2:0], 1'b0};
            mul_reg   <= {1'b0, mul_reg[MW-1:1]};
            if (cnt_reg == 6'(MW - 1))
            begin
                sq_reg[idx_reg] <= acc_add;
            end
        end
    end

endmodule

/* rtl/dcc_queue.sv */
// Two-entry queue of classified requests between front and back.
// Uses dcc_pkg for the entry type.
module dcc_queue
    import dcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic q_full,
    input  logic rd_en,
    output job_t rd_job,
    output logic q_empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_job  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

/* rtl/dcc_back.sv */
// Back end: walks the sample columns of a partial cell, forms each half
// chord with an iterative square root, and holds the result register.
// Uses dcc_pkg.
module dcc_back
    import dcc_pkg::*;
#(
    parameter int SAMPLE_INTERVALS = 1000
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  job_t              job,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [COVW-1:0]   coverage,
    output logic [1:0]        case_kind
);

    localparam int D2    = 2 * SAMPLE_INTERVALS;
    localparam int QSTEP = 131072 / D2;
    localparam int RSTEP = 131072 % D2;
    localparam int IW    = $clog2(SAMPLE_INTERVALS + 1);
    localparam int OW    = $clog2(D2) + 1;
    localparam int SW    = $clog2(QSTEP + 2);
    localparam int PW    = CW + SW + 1;

    // Final scaling by 1/D2 as a reciprocal multiply. Below the saturation
    // limit the dividend fits in QN bits, so an RK-bit reciprocal is exact.
    localparam int LD  = $clog2(D2);
    localparam int QN  = COVW + LD;
    localparam int RK  = QN + LD;
    localparam int MUW = QN + 2;
    localparam logic [63:0] RECIP64 = ((64'd1 << RK) + 64'(D2) - 64'd1) / 64'(D2);
    localparam logic [MUW-1:0]  RECIP   = RECIP64[MUW-1:0];
    localparam logic [ACCW-1:0] SAT_LIM = ACCW'((int'(FULL_COVER) + 1) * D2);

    typedef enum logic [2:0] {B_IDLE, B_COL, B_SQRT, B_ACC, B_DIV, B_DONE} bstate_t;

    bstate_t               state_reg;
    logic [5:0]            step_reg;
    logic [IW-1:0]         i_reg;
    logic                  out_valid_reg;
    logic [COVW-1:0]       coverage_reg;
    logic [1:0]            kind_reg;

    logic [1:0]            res_kind_reg;
    logic [COVW-1:0]       res_cov_reg;
    logic signed [CW-1:0]  d_reg, ay_reg;
    logic [SQW-1:0]        d2_reg;
    logic [R2W-1:0]        r2_reg, rad_reg;
    logic [OW-1:0]         orem_reg;
    logic [MW-1:0]         srem_reg;
    logic [RW-1:0]         root_reg;
    logic                  chord_reg;
    logic [ACCW-1:0]       acc_reg, dq_reg;

    logic [OW-1:0]         rsum;
    logic                  carry;
    logic [SW-1:0]         s;
    logic [2*SW-1:0]       s_sq;
    logic signed [PW-1:0]  prod;
    logic signed [SQW+1:0] d2_sum;
    logic                  has_chord;
    logic [MW+1:0]         trem, trial;
    logic                  root_bit;
    logic signed [CW-1:0]  hs, nh, dy, top, bot, diff;
    logic [LENW-1:0]       len;
    logic [ACCW-1:0]       wlen, acc_new;
    logic [QN-1:0]         qx;
    logic [QN+MUW-1:0]     qprod;
    logic [COVW-1:0]       quot;
    logic                  out_load;
    logic                  last_col;

    // Column offset advances by QSTEP or QSTEP+1 with a running remainder.
    assign rsum  = orem_reg + OW'(RSTEP);
    assign carry = (rsum >= OW'(D2));
    assign s     = SW'(QSTEP) + SW'(carry);
    assign s_sq  = s * s;
    assign prod  = d_reg * $signed({1'b0, s});
    assign d2_sum = $signed({2'b00, d2_reg}) + ((SQW+2)'(prod) <<< 1)
                    + $signed({{(SQW+2-2*SW){1'b0}}, s_sq});

    assign has_chord = ({{(SQW-R2W){1'b0}}, r2_reg} > d2_reg);

    // Digit-by-digit square root: two radicand bits in, one root bit out.
    assign trem     = {srem_reg, rad_reg[R2W-1:R2W-2]};
    assign trial    = {{(MW+2-RW-2){1'b0}}, root_reg, 2'b01};
    assign root_bit = (trem >= trial);

    assign hs   = $signed({{(CW-RW){1'b0}}, root_reg});
    assign nh   = -hs;
    assign dy   = ay_reg + CELL_ONE;
    assign top  = (hs < dy) ? hs : dy;
    assign bot  = (nh > ay_reg) ? nh : ay_reg;
    assign diff = top - bot;
    assign len  = (chord_reg && top > bot) ? diff[LENW-1:0] : '0;

    assign last_col = (i_reg == IW'(SAMPLE_INTERVALS));
    assign wlen     = (i_reg == '0 || last_col) ? ACCW'(len) : ACCW'({len, 1'b0});
    assign acc_new  = acc_reg + wlen;

    assign qx    = dq_reg[QN-1:0];
    assign qprod = qx * RECIP;
    assign quot  = qprod[RK+COVW-1:RK];

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign out_load = (state_reg == B_DONE) && (!out_valid_reg || pop);

    assign empty     = !out_valid_reg;
    assign coverage  = coverage_reg;
    assign case_kind = kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
            coverage_reg  <= '0;
            kind_reg      <= KIND_OUTSIDE;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                coverage_reg  <= res_cov_reg;
                kind_reg      <= res_kind_reg;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        i_reg     <= '0;
                        state_reg <= (job.kind == KIND_PARTIAL) ? B_COL : B_DONE;
                    end
                end
                B_COL:
                begin
                    step_reg  <= '0;
                    state_reg <= has_chord ? B_SQRT : B_ACC;
                end
                B_SQRT:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(RW - 1))
                    begin
                        state_reg <= B_ACC;
                    end
                end
                B_ACC:
                begin
                    step_reg <= '0;
                    if (last_col)
                    begin
                        state_reg <= B_DIV;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IW'(1);
                        state_reg <= B_COL;
                    end
                end
                B_DIV:
                begin
                    state_reg <= B_DONE;
                end
                B_DONE:
                begin
                    if (!out_valid_reg || pop)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    res_kind_reg <= job.kind;
                    res_cov_reg  <= (job.kind == KIND_INSIDE) ? FULL_COVER : '0;
                    d_reg        <= $signed(job.ax);
                    ay_reg       <= $signed(job.ay);
                    d2_reg       <= job.ax2;
                    r2_reg       <= job.r2;
                    orem_reg     <= OW'(SAMPLE_INTERVALS);
                    acc_reg      <= '0;
                end
            end
            B_COL:
            begin
                chord_reg <= has_chord;
                rad_reg   <= r2_reg - d2_reg[R2W-1:0];
                srem_reg  <= '0;
                root_reg  <= '0;
            end
            B_SQRT:
            begin
                rad_reg  <= {rad_reg[R2W-3:0], 2'b00};
                srem_reg <= root_bit ? MW'(trem - trial) : trem[MW-1:0];
                root_reg <= {root_reg[RW-2:0], root_bit};
            end
            B_ACC:
            begin
                acc_reg  <= acc_new;
                dq_reg   <= acc_new + ACCW'(SAMPLE_INTERVALS);
                orem_reg <= carry ? rsum - OW'(D2) : rsum;
                d_reg    <= d_reg + $signed({{(CW-SW){1'b0}}, s});
                d2_reg   <= d2_sum[SQW-1:0];
            end
            B_DIV:
            begin
                // Saturate at full coverage, else take the scaled quotient.
                res_cov_reg <= (dq_reg >= SAT_LIM) ? FULL_COVER : quot;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/disc_cell_coverage.sv */
// Top level of the disc cell coverage block: configuration register, front
// end, request queue and back end. Uses dcc_pkg, dcc_front, dcc_queue, dcc_back.
//
// Usage:
//   Requests enter on push/full: a cell index, a disc centre and a radius
//   (Q16.16). Results leave on empty/pop: coverage (Q1.16, 65536 is full)
//   and case_kind (outside, inside, partial). cfg_data sets cells per unit
//   length (zero acts as one) through cfg_valid/cfg_ready, ready always high.
// Operation:
//   The front end scales and classifies one request at a time; its six
//   squares share one shift-add unit that retires one bit a cycle. It takes
//   a new request only after pushing the last one into the queue.
//   Outside and inside cells go from idle straight to the done state.
//   Partial cells walk SAMPLE_INTERVALS+1 columns; each column is set up,
//   put through the square root unit (only where it meets the disc), which
//   yields one root bit a cycle, and accumulated. A final scaling step
//   follows the last column.
//   A two-entry queue lets the front classify later requests meanwhile.
// Reset and stall:
//   Reset empties the queue and result register and sets cells per unit to
//   one. While empty is low and pop is low the result holds; the back end
//   then waits with its finished result, the queue fills and full stays high.
module disc_cell_coverage
    import dcc_pkg::*;
#(
    parameter int SAMPLE_INTERVALS = 1000
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [NW-1:0]      cfg_data,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] cell_x,
    input  logic signed [15:0] cell_y,
    input  logic signed [31:0] centre_x,
    input  logic signed [31:0] centre_y,
    input  logic [30:0]        radius,
    output logic               empty,
    input  logic               pop,
    output logic [COVW-1:0]    coverage,
    output logic [1:0]         case_kind
);

    logic [NW-1:0] cells_per_unit_reg;
    job_t          front_job, back_job;
    logic          job_push, q_full, q_empty, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_per_unit_reg <= NW'(1);
        end
        else if (cfg_valid)
        begin
            cells_per_unit_reg <= cfg_data;
        end
    end

    dcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .n_cfg    (cells_per_unit_reg),
        .push     (push),
        .full     (full),
        .cell_x   (cell_x),
        .cell_y   (cell_y),
        .centre_x (centre_x),
        .centre_y (centre_y),
        .radius   (radius),
        .job      (front_job),
        .job_push (job_push),
        .job_full (q_full)
    );

    dcc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (front_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_job  (back_job),
        .q_empty (q_empty)
    );

    dcc_back #(
        .SAMPLE_INTERVALS (SAMPLE_INTERVALS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .coverage  (coverage),
        .case_kind (case_kind)
    );

endmodule

/* rtl/dcc_checker.sv */
// Port-level checks of the disc cell coverage result channel, bound to the
// top level. Uses dcc_pkg and disc_cell_coverage_macros.svh.
`include "disc_cell_coverage_macros.svh"

module dcc_checker
    import dcc_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            empty,
    input logic            pop,
    input logic [COVW-1:0] coverage,
    input logic [1:0]      case_kind
);

    `DCC_ASSERT_IMP(a_outside_zero, !empty && case_kind == KIND_OUTSIDE, coverage == '0, "outside cell with nonzero coverage")
    `DCC_ASSERT_IMP(a_inside_full, !empty && case_kind == KIND_INSIDE, coverage == FULL_COVER, "inside cell not fully covered")
    `DCC_ASSERT_IMP(a_cov_range, !empty, coverage <= FULL_COVER, "coverage above full")
    `DCC_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(coverage) && $stable(case_kind), "result changed while stalled")

endmodule

bind disc_cell_coverage dcc_checker u_dcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .coverage  (coverage),
    .case_kind (case_kind)
);
